FILE: rtl/bsa_pkg.sv
// bsa_pkg: shared constants, command codes and the cell control struct
// for the slot allocator. No dependencies.
package bsa_pkg;

    localparam int SLOT_BYTES      = 32;
    localparam int SLOT_SHIFT      = 5;
    localparam int MAX_ALLOC_BYTES = 256;
    localparam int RUN_W           = 8;
    localparam int MAX_STEPS       = 11;
    localparam int IDX_W           = 12;
    localparam int SIZE_W          = 10;
    localparam int OFFS_W          = 13;
    localparam int GRANT_W         = 12;
    localparam int USED_W          = 13;
    localparam int TOTAL_W         = 16;
    localparam int COUNT_W         = 6;

    localparam logic [USED_W-1:0] USED_MAX = '1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_HOLD  = 3'd0;
    localparam t_cmd CMD_LOAD  = 3'd1;
    localparam t_cmd CMD_SCAN  = 3'd2;
    localparam t_cmd CMD_MARK  = 3'd3;
    localparam t_cmd CMD_CLEAR = 3'd4;

    typedef struct packed {
        t_cmd                   cmd;
        logic [RUN_W-1:0]       need_mask;
        logic [MAX_STEPS-1:0]   step_oh;
        logic [IDX_W-1:0]       lo;
        logic [IDX_W-1:0]       hi;
    } t_cell_ctrl;

endpackage

FILE: rtl/bsa_cell.sv
// bsa_cell: one slot of the allocator row, holding its occupancy bit,
// its fit flag and its running prefix flag. Depends on bsa_pkg.
module bsa_cell #(
    parameter logic [bsa_pkg::IDX_W-1:0] CELL_ID = '0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bsa_pkg::t_cell_ctrl               i_ctrl,
    input  logic [bsa_pkg::RUN_W-1:1]         i_occ_ahead,
    input  logic [bsa_pkg::RUN_W-1:1]         i_win_behind,
    input  logic                              i_pre_prev,
    input  logic [bsa_pkg::MAX_STEPS-1:0]     i_pre_far,
    output logic                              o_occ,
    output logic                              o_pre,
    output logic                              o_win
);

    logic r_occ;
    logic r_fit;
    logic r_pre;
    logic w_fit;
    logic w_mark;
    logic w_in_range;
    logic w_far;

    assign w_fit      = ~|({i_occ_ahead, r_occ} & i_ctrl.need_mask);
    assign o_win      = r_fit & ~i_pre_prev;
    assign w_mark     = |({i_win_behind, o_win} & i_ctrl.need_mask);
    assign w_in_range = (CELL_ID >= i_ctrl.lo) && (CELL_ID < i_ctrl.hi);
    assign w_far      = |(i_pre_far & i_ctrl.step_oh);

    assign o_occ = r_occ;
    assign o_pre = r_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_fit <= 1'b0;
            r_pre <= 1'b0;
        end else begin
            unique case (i_ctrl.cmd)
                bsa_pkg::CMD_LOAD: begin
                    r_fit <= w_fit;
                    r_pre <= w_fit;
                end
                bsa_pkg::CMD_SCAN: begin
                    r_pre <= r_pre | w_far;
                end
                bsa_pkg::CMD_MARK: begin
                    r_occ <= r_occ | w_mark;
                end
                bsa_pkg::CMD_CLEAR: begin
                    if (w_in_range) begin
                        r_occ <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/bitmap_slot_allocator.sv
// bitmap_slot_allocator: top level with the request sequencer, the row of
// slot cells and the result register. Depends on bsa_pkg and bsa_cell.
//
// Usage: requests enter on i_valid/o_stall with i_opcode, i_size_bytes and
// i_free_offset; one result per request leaves on o_valid/i_stall with
// o_ok, o_grant_offset, o_used_bytes and o_alloc_total. A transaction
// completes at a clock edge with valid high and stall low.
// An allocate loads the fit flags, runs the prefix scan across the cell row
// (128 slots at the default pool) with one doubling step per cycle, marks
// the run and registers the result. A free clears its slot range and then
// registers the result; a rejected request registers its result directly.
// One request is in progress at a time; o_stall is high until its result
// is registered.
// A result waiting on i_stall does not block the next request, but that
// request holds in its last cycle until the output register is free.
// After reset every slot is free, both counts are zero and o_valid is low.
module bitmap_slot_allocator #(
    parameter int POOL_BYTES    = 4096,
    parameter int MAX_RUN_SLOTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_opcode,
    input  logic [bsa_pkg::SIZE_W-1:0]      i_size_bytes,
    input  logic [bsa_pkg::OFFS_W-1:0]      i_free_offset,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_ok,
    output logic [bsa_pkg::GRANT_W-1:0]     o_grant_offset,
    output logic [bsa_pkg::USED_W-1:0]      o_used_bytes,
    output logic [bsa_pkg::TOTAL_W-1:0]     o_alloc_total
);

    localparam int NUM_SLOTS = POOL_BYTES / bsa_pkg::SLOT_BYTES;
    localparam int SW        = $clog2(NUM_SLOTS);
    localparam int STEPS     = SW;
    localparam int POOL_W    = 17;
    localparam int RUN_W     = bsa_pkg::RUN_W;
    localparam int MAX_STEPS = bsa_pkg::MAX_STEPS;
    localparam int IDX_W     = bsa_pkg::IDX_W;
    localparam int SIZE_W    = bsa_pkg::SIZE_W;
    localparam int OFFS_W    = bsa_pkg::OFFS_W;
    localparam int GRANT_W   = bsa_pkg::GRANT_W;
    localparam int USED_W    = bsa_pkg::USED_W;
    localparam int TOTAL_W   = bsa_pkg::TOTAL_W;
    localparam int COUNT_W   = bsa_pkg::COUNT_W;
    localparam int SHIFT     = bsa_pkg::SLOT_SHIFT;
    localparam int AMT_W     = COUNT_W + SHIFT;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [NUM_SLOTS-1:0] f_bit_mask(input int b);
        logic [NUM_SLOTS-1:0] m;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m[i] = 1'((i >> b) & 1);
        end
        return m;
    endfunction

    logic [2:0]             r_state;
    logic                   r_op;
    logic                   r_ok;
    logic [COUNT_W-1:0]     r_need;
    logic [IDX_W-1:0]       r_lo;
    logic [IDX_W-1:0]       r_hi;
    logic [MAX_STEPS-1:0]   r_step;
    logic [SW-1:0]          r_idx;
    logic [USED_W-1:0]      r_used;
    logic [TOTAL_W-1:0]     r_total;
    logic                   r_o_valid;
    logic                   r_o_ok;
    logic [GRANT_W-1:0]     r_o_grant;
    logic [USED_W-1:0]      r_o_used;
    logic [TOTAL_W-1:0]     r_o_total;

    logic                           w_accept;
    logic                           w_can_load;
    logic [SIZE_W:0]                w_size_sum;
    logic [COUNT_W-1:0]             w_need;
    logic                           w_alloc_bad;
    logic                           w_free_bad;
    logic [SHIFT+3-1:0]             w_start;
    logic [AMT_W-1:0]               w_amount;
    logic [USED_W:0]                w_add_sum;
    logic [SW+GRANT_W-1:0]          w_off_ext;
    logic                           w_found;
    logic [SW-1:0]                  w_idx;
    logic [RUN_W-1:0]               w_need_mask;
    bsa_pkg::t_cmd                  w_cmd;
    bsa_pkg::t_cell_ctrl            w_ctrl;
    logic [NUM_SLOTS-1:0]           w_occ;
    logic [NUM_SLOTS-1:0]           w_pre;
    logic [NUM_SLOTS-1:0]           w_win;
    logic [NUM_SLOTS+RUN_W-1:0]     w_occ_ext;
    logic [NUM_SLOTS+RUN_W-2:0]     w_win_ext;

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign w_can_load  = !r_o_valid || !i_stall;

    assign w_size_sum  = (SIZE_W+1)'(i_size_bytes) + (SIZE_W+1)'(bsa_pkg::SLOT_BYTES - 1);
    assign w_need      = w_size_sum[SIZE_W:SHIFT];
    assign w_alloc_bad = (i_size_bytes == '0)
                      || (i_size_bytes > SIZE_W'(bsa_pkg::MAX_ALLOC_BYTES))
                      || (w_need > COUNT_W'(MAX_RUN_SLOTS));
    assign w_free_bad  = POOL_W'(i_free_offset) >= POOL_W'(POOL_BYTES);
    assign w_start     = i_free_offset[OFFS_W-1:SHIFT];

    assign w_amount    = {r_need, {SHIFT{1'b0}}};
    assign w_add_sum   = (USED_W+1)'(r_used) + (USED_W+1)'(w_amount);
    assign w_off_ext   = (SW+GRANT_W)'({r_idx, {SHIFT{1'b0}}});

    assign w_found     = w_pre[NUM_SLOTS-1];
    assign w_occ_ext   = {{RUN_W{1'b1}}, w_occ};
    assign w_win_ext   = {w_win, {(RUN_W-1){1'b0}}};

    always_comb begin
        for (int k = 0; k < RUN_W; k++) begin
            w_need_mask[k] = (COUNT_W'(k) < r_need);
        end
    end

    always_comb begin
        unique case (r_state)
            S_LOAD:  w_cmd = bsa_pkg::CMD_LOAD;
            S_SCAN:  w_cmd = bsa_pkg::CMD_SCAN;
            S_MARK:  w_cmd = bsa_pkg::CMD_MARK;
            S_CLEAR: w_cmd = bsa_pkg::CMD_CLEAR;
            default: w_cmd = bsa_pkg::CMD_HOLD;
        endcase
    end

    assign w_ctrl.cmd       = w_cmd;
    assign w_ctrl.need_mask = w_need_mask;
    assign w_ctrl.step_oh   = r_step;
    assign w_ctrl.lo        = r_lo;
    assign w_ctrl.hi        = r_hi;

    // winner index, one bit of the one-hot encoder per output bit
    genvar b;
    generate
        for (b = 0; b < SW; b++) begin : g_enc
            assign w_idx[b] = |(w_win & f_bit_mask(b));
        end
    endgenerate

    genvar i;
    genvar k;
    generate
        for (i = 0; i < NUM_SLOTS; i++) begin : g_cell
            logic [RUN_W-1:1]     w_ahead;
            logic [RUN_W-1:1]     w_behind;
            logic [MAX_STEPS-1:0] w_far;
            logic                 w_prev;

            for (k = 1; k < RUN_W; k++) begin : g_win
                assign w_ahead[k]  = w_occ_ext[i+k];
                assign w_behind[k] = w_win_ext[i+RUN_W-1-k];
            end

            for (k = 0; k < MAX_STEPS; k++) begin : g_far
                if ((1 << k) <= i) begin : g_tap
                    assign w_far[k] = w_pre[i-(1 << k)];
                end else begin : g_zero
                    assign w_far[k] = 1'b0;
                end
            end

            if (i == 0) begin : g_first
                assign w_prev = 1'b0;
            end else begin : g_rest
                assign w_prev = w_pre[i-1];
            end

            bsa_cell #(
                .CELL_ID (IDX_W'(i))
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_occ_ahead  (w_ahead),
                .i_win_behind (w_behind),
                .i_pre_prev   (w_prev),
                .i_pre_far    (w_far),
                .o_occ        (w_occ[i]),
                .o_pre        (w_pre[i]),
                .o_win        (w_win[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= bsa_pkg::OP_ALLOC;
            r_ok    <= 1'b0;
            r_need  <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_step  <= '0;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_opcode;
                        r_ok   <= 1'b0;
                        r_need <= w_need;
                        r_lo   <= IDX_W'(w_start);
                        r_hi   <= IDX_W'(w_start) + IDX_W'(w_need);
                        if (i_opcode == bsa_pkg::OP_ALLOC) begin
                            r_state <= w_alloc_bad ? S_DONE : S_LOAD;
                        end else begin
                            r_state <= w_free_bad ? S_DONE : S_CLEAR;
                        end
                    end
                end
                S_LOAD: begin
                    r_step  <= MAX_STEPS'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_step <= r_step << 1;
                    if (r_step[STEPS-1]) begin
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_ok <= w_found;
                    if (w_found) begin
                        r_used  <= (w_add_sum > (USED_W+1)'(bsa_pkg::USED_MAX))
                                 ? bsa_pkg::USED_MAX : w_add_sum[USED_W-1:0];
                        r_total <= r_total + TOTAL_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_CLEAR: begin
                    r_ok    <= 1'b1;
                    r_used  <= (r_used < USED_W'(w_amount))
                             ? '0 : r_used - USED_W'(w_amount);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MARK) begin
            r_idx <= w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && w_can_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_can_load) begin
            r_o_ok    <= r_ok;
            r_o_grant <= (r_ok && r_op == bsa_pkg::OP_ALLOC)
                       ? w_off_ext[GRANT_W-1:0] : '0;
            r_o_used  <= r_used;
            r_o_total <= r_total;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_ok           = r_o_ok;
    assign o_grant_offset = r_o_grant;
    assign o_used_bytes   = r_o_used;
    assign o_alloc_total  = r_o_total;

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && w_found) |=> (r_total == $past(r_total) + TOTAL_W'(1)))
        else $error("allocation count did not advance on a grant");

    a_step_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> $onehot(r_step))
        else $error("scan step is not one-hot");

    a_single_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> $onehot0(w_win))
        else $error("more than one winning slot");

    a_free_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_used <= $past(r_used)))
        else $error("used count rose on a free");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction left sequencer idle");

endmodule
